// ===== rtl/pffl_pkg.sv =====
// Shared types and constants of the page frame free list allocator.
package pffl_pkg;

  localparam int unsigned FRAME_BITS_DEF = 20;
  localparam int unsigned PAGE_SHIFT     = 12;
  localparam int unsigned CFG_W          = 33;
  localparam int unsigned COUNT_W        = 21;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned PADDR_W        = 4;

  localparam logic [CFG_W-1:0] WINDOW_LOW_RST  = 33'h0_0080_0000;
  localparam logic [CFG_W-1:0] WINDOW_HIGH_RST = 33'h1_0000_0000;

  localparam logic [31:0] TYPE_USABLE = 32'd1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_MISALIGNED = 2'd2
  } status_e;

  typedef enum logic {
    REG_WINDOW_LOW  = 1'b0,
    REG_WINDOW_HIGH = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_ADD_PREP,
    S_ADD_CLIP,
    S_ADD_WALK,
    S_RESP
  } state_e;

endpackage

// ===== rtl/pffl_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module pffl_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/page_frame_free_list_top.sv =====
// Top level of the page frame free list allocator.
// Free 4 KiB frames form a singly linked list whose next pointers live in one single-port RAM
// of 2^FRAME_BITS entries; head, tail and count are registers. The RAM is not cleared after
// reset and needs no clearing pass, so items are taken right away. One item is worked on at a
// time: a free, a rejected add or an empty allocate goes from S_IDLE straight to S_RESP; an
// allocate passes S_ALLOC, as it reads the next pointer of the head and then writes it back
// to zero; a region add passes S_ADD_PREP, S_ADD_CLIP and S_ADD_WALK, which appends one page
// at a time, by a RAM write unless the list is empty. The result waits in an output register.
module page_frame_free_list_top #(
  parameter int unsigned FRAME_BITS = pffl_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pffl_pkg::PADDR_W-1:0]  paddr,
  input  logic [pffl_pkg::DATA_W-1:0]   pwdata,
  output logic [pffl_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [63:0]                   region_base_i,
  input  logic [63:0]                   region_length_i,
  input  logic [31:0]                   region_type_i,
  input  logic [31:0]                   freed_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   page_address_o,
  output logic [1:0]                    status_o,
  output logic [pffl_pkg::COUNT_W-1:0]  free_count_o
);

  import pffl_pkg::*;

  localparam int unsigned FW = FRAME_BITS + 1;
  localparam logic [FW-1:0] FRAME_TOP = {1'b1, {FRAME_BITS{1'b0}}};

  function automatic logic [FW-1:0] clamp_frame(input logic [52:0] v);
    logic [FW-1:0] r;
    if (v[52:FW] != '0 || v[FW-1:0] > FRAME_TOP) begin
      r = FRAME_TOP;
    end else begin
      r = v[FW-1:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [CFG_W-1:0]      win_low_q, win_high_q;
  logic [FRAME_BITS-1:0] head_q, head_d, tail_q, tail_d;
  logic [COUNT_W-1:0]    count_q, count_d, count_inc;
  logic                  started_q, started_d;
  logic [63:0]           base_q, len_q;
  logic [FW-1:0]         endc_q, basec_q, lowc_q, highc_q;
  logic [FW-1:0]         cur_q, cur_d, lim_q, lim_d;
  logic [31:0]           res_addr_q, res_addr_d;
  status_e               res_status_q, res_status_d;
  logic                  out_valid_q;
  logic [31:0]           out_addr_q;
  logic [1:0]            out_status_q;
  logic [COUNT_W-1:0]    out_count_q;

  logic                  in_acc, cfg_wr, list_empty, out_free, walk_go, freed_aligned;
  logic [FRAME_BITS-1:0] freed_frame;
  logic [64:0]           sum_w;
  logic [63:0]           end_w;
  logic [52:0]           basef_w;
  logic [21:0]           lowf_w, highf_w;

  logic                  ram_en, ram_we;
  logic [FRAME_BITS-1:0] ram_addr, ram_wdata, ram_rdata;

  assign in_acc        = in_valid_i && in_ready_o;
  assign in_ready_o    = (state_q == S_IDLE);
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign pready        = 1'b1;
  assign list_empty    = !started_q || (count_q == '0);
  assign count_inc     = (count_q != '1) ? count_q + 1'b1 : count_q;
  assign out_free      = !out_valid_q || out_ready_i;
  assign walk_go       = cur_q < lim_q;
  assign freed_aligned = (freed_address_i[PAGE_SHIFT-1:0] == '0);
  assign freed_frame   = freed_address_i[FRAME_BITS+PAGE_SHIFT-1:PAGE_SHIFT];

  assign sum_w   = {1'b0, base_q} + {1'b0, len_q};
  assign end_w   = sum_w[64] ? '1 : sum_w[63:0];
  assign basef_w = {1'b0, base_q[63:PAGE_SHIFT]} + 53'(base_q[PAGE_SHIFT-1:0] != '0);
  assign lowf_w  = {1'b0, win_low_q[CFG_W-1:PAGE_SHIFT]}
                 + 22'(win_low_q[PAGE_SHIFT-1:0] != '0);
  assign highf_w = {1'b0, win_high_q[CFG_W-1:PAGE_SHIFT]}
                 + 22'(win_high_q[PAGE_SHIFT-1:0] != '0);

  always_comb begin
    unique case (reg_e'(paddr[3]))
      REG_WINDOW_LOW:  prdata = DATA_W'(win_low_q);
      REG_WINDOW_HIGH: prdata = DATA_W'(win_high_q);
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_ALLOC: state_d = (count_q != '0) ? S_ALLOC : S_RESP;
            KIND_ADD:   state_d = (region_type_i == TYPE_USABLE) ? S_ADD_PREP : S_RESP;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_ALLOC:    state_d = S_RESP;
      S_ADD_PREP: state_d = S_ADD_CLIP;
      S_ADD_CLIP: state_d = S_ADD_WALK;
      S_ADD_WALK: state_d = walk_go ? S_ADD_WALK : S_RESP;
      S_RESP:     state_d = out_free ? S_IDLE : S_RESP;
    endcase
  end

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    started_d    = started_q;
    cur_d        = cur_q;
    lim_d        = lim_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = head_q;
    ram_wdata    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_addr_d   = '0;
          res_status_d = ST_OK;
          case (kind_i)
            KIND_ALLOC: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                ram_en   = 1'b1;
                ram_addr = head_q;
              end
            end
            KIND_FREE: begin
              if (!freed_aligned) begin
                res_status_d = ST_MISALIGNED;
              end else begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = freed_frame;
                ram_wdata = list_empty ? '0 : head_q;
                if (list_empty) begin
                  tail_d = freed_frame;
                end
                head_d    = freed_frame;
                started_d = 1'b1;
                count_d   = count_inc;
              end
            end
            default: ;
          endcase
        end
      end
      S_ALLOC: begin
        ram_en     = 1'b1;
        ram_we     = 1'b1;
        ram_addr   = head_q;
        ram_wdata  = '0;
        res_addr_d = 32'({head_q, {PAGE_SHIFT{1'b0}}});
        head_d     = ram_rdata;
        count_d    = count_q - 1'b1;
      end
      S_ADD_CLIP: begin
        lim_d = (endc_q < highc_q) ? endc_q : highc_q;
        cur_d = (basec_q > lowc_q) ? basec_q : lowc_q;
      end
      S_ADD_WALK: begin
        if (walk_go) begin
          if (list_empty) begin
            head_d = cur_q[FRAME_BITS-1:0];
          end else begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = tail_q;
            ram_wdata = cur_q[FRAME_BITS-1:0];
          end
          tail_d    = cur_q[FRAME_BITS-1:0];
          started_d = 1'b1;
          count_d   = count_inc;
          cur_d     = cur_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_low_q   <= WINDOW_LOW_RST;
      win_high_q  <= WINDOW_HIGH_RST;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      started_q <= started_d;
      if (cfg_wr) begin
        unique case (reg_e'(paddr[3]))
          REG_WINDOW_LOW:  win_low_q  <= pwdata[CFG_W-1:0];
          REG_WINDOW_HIGH: win_high_q <= pwdata[CFG_W-1:0];
        endcase
      end
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    lim_q        <= lim_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (in_acc) begin
      base_q <= region_base_i;
      len_q  <= region_length_i;
    end
    if (state_q == S_ADD_PREP) begin
      endc_q  <= clamp_frame({1'b0, end_w[63:PAGE_SHIFT]});
      basec_q <= clamp_frame(basef_w);
      lowc_q  <= clamp_frame(53'(lowf_w));
      highc_q <= clamp_frame(53'(highf_w));
    end
    if (state_q == S_RESP && out_free) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
      out_count_q  <= count_q;
    end
  end

  pffl_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (2 ** FRAME_BITS)
  ) u_next_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign page_address_o = out_addr_q;
  assign status_o       = out_status_q;
  assign free_count_o   = out_count_q;

  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> page_address_o == '0)
    else $error("Failed item carries a page address.");

  a_alloc_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ALLOC |-> $past(ram_en && !ram_we && ram_addr == head_q))
    else $error("Allocate without a prior read of the head pointer.");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ALLOC |=> count_q == $past(count_q) - 1'b1)
    else $error("Allocate did not take one page off the count.");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADD_WALK && ram_we |-> cur_q < lim_q)
    else $error("Region walk appended a page beyond its limit.");

endmodule

// ===== test/tb_page_frame_free_list_top.sv =====
// Self-checking testbench for the page frame free list allocator with a free-list predictor.
`timescale 1ns / 1ps

module tb_page_frame_free_list_top;
  import pffl_pkg::*;

  localparam int unsigned FB = FRAME_BITS_DEF;
  localparam logic [63:0] FRAME_TOP = 64'd1 << (FB + PAGE_SHIFT);
  localparam logic [63:0] PAGE = 64'd4096;

  typedef struct {
    kind_e       kind;
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] rtype;
    logic [31:0] freed;
  } page_req_t;

  typedef struct {
    logic [31:0]        page;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } page_resp_t;

  class frame_list_board;
    logic [CFG_W-1:0]   win_low;
    logic [CFG_W-1:0]   win_high;
    logic [FB-1:0]      head_frame;
    logic [FB-1:0]      tail_frame;
    logic [COUNT_W-1:0] pages_free;
    bit                 started;
    logic [FB-1:0]      nxt_of [logic [FB-1:0]];
    page_resp_t         pending_q[$];
    int                 errors;

    function new();
      win_low    = WINDOW_LOW_RST;
      win_high   = WINDOW_HIGH_RST;
      head_frame = '0;
      tail_frame = '0;
      pages_free = '0;
      started    = 1'b0;
      errors     = 0;
    endfunction

    function void set_window(reg_e r, logic [CFG_W-1:0] v);
      if (r == REG_WINDOW_LOW) begin
        win_low = v;
      end else begin
        win_high = v;
      end
    endfunction

    function page_resp_t note_item(page_req_t it);
      page_resp_t  res;
      logic [63:0] fin, start, lo, limit, p;
      logic [FB-1:0] f;
      res.page   = '0;
      res.status = ST_OK;
      case (it.kind)
        KIND_ADD: begin
          if (it.rtype == TYPE_USABLE && it.base <= 64'hFFFF_FFFF_FFFF_F000) begin
            fin = it.base + it.length;
            if (fin < it.base) fin = '1;
            start = (it.base + 64'hFFF) & ~64'hFFF;
            lo = ({31'b0, win_low} + 64'hFFF) & ~64'hFFF;
            if (lo > start) start = lo;
            limit = ({31'b0, win_high} < FRAME_TOP) ? {31'b0, win_high} : FRAME_TOP;
            for (p = start; p < limit && fin >= PAGE && p <= fin - PAGE; p += PAGE) begin
              f = p[PAGE_SHIFT +: FB];
              if (!started || pages_free == 0) begin
                head_frame = f;
              end else begin
                nxt_of[tail_frame] = f;
              end
              tail_frame = f;
              started = 1'b1;
              if (pages_free != '1) pages_free++;
            end
          end
        end
        KIND_ALLOC: begin
          if (pages_free == 0) begin
            res.status = ST_EMPTY;
          end else begin
            f = head_frame;
            res.page = 32'({f, 12'b0});
            head_frame = nxt_of.exists(f) ? nxt_of[f] : '0;
            nxt_of[f] = '0;
            pages_free--;
          end
        end
        KIND_FREE: begin
          if (it.freed[11:0] != 0) begin
            res.status = ST_MISALIGNED;
          end else begin
            f = it.freed[PAGE_SHIFT +: FB];
            if (!started || pages_free == 0) begin
              tail_frame = f;
              nxt_of[f] = '0;
            end else begin
              nxt_of[f] = head_frame;
            end
            head_frame = f;
            started = 1'b1;
            if (pages_free != '1) pages_free++;
          end
        end
        default: begin
        end
      endcase
      res.count = pages_free;
      pending_q.push_back(res);
      return res;
    endfunction

    function void check_result(logic [31:0] pa, logic [1:0] st, logic [COUNT_W-1:0] fc);
      page_resp_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result page %h status %0d count %0d", $time, pa, st, fc);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (want.page != pa) begin
          $display("%0t: page_address expected %h actual %h", $time, want.page, pa);
          errors++;
        end
        if (want.status != status_e'(st)) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, st);
          errors++;
        end
        if (want.count != fc) begin
          $display("%0t: free_count expected %0d actual %0d", $time, want.count, fc);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           kind_i;
  logic [63:0]          region_base_i;
  logic [63:0]          region_length_i;
  logic [31:0]          region_type_i;
  logic [31:0]          freed_address_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [31:0]          page_address_o;
  logic [1:0]           status_o;
  logic [COUNT_W-1:0]   free_count_o;

  frame_list_board board;
  logic [31:0]     handed_out[$];
  bit              calm;

  page_frame_free_list_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .region_base_i   (region_base_i),
    .region_length_i (region_length_i),
    .region_type_i   (region_type_i),
    .freed_address_i (freed_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .page_address_o  (page_address_o),
    .status_o        (status_o),
    .free_count_o    (free_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(page_address_o, status_o, free_count_o);
    end
  end

  function automatic page_req_t make_req(kind_e k, logic [63:0] b, logic [63:0] l,
                                         logic [31:0] t, logic [31:0] f);
    page_req_t it;
    it.kind   = k;
    it.base   = b;
    it.length = l;
    it.rtype  = t;
    it.freed  = f;
    return it;
  endfunction

  function automatic page_req_t pick_request(int add_pct, int alloc_pct);
    page_req_t   it;
    int          r, s, idx;
    logic [63:0] glo, ghi, span, lo_b;
    it = make_req(KIND_ALLOC, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
    r = $urandom_range(99);
    if (r < add_pct) begin
      it.kind = KIND_ADD;
      s = $urandom_range(9);
      if (s < 7) begin
        glo = ({31'b0, board.win_low} > FRAME_TOP) ? FRAME_TOP : {31'b0, board.win_low};
        ghi = ({31'b0, board.win_high} > FRAME_TOP) ? FRAME_TOP : {31'b0, board.win_high};
        span = (ghi > glo) ? ghi - glo : 64'h4_0000;
        lo_b = (glo > 64'h8000) ? glo - 64'h8000 : 64'd0;
        it.base = lo_b + ({$urandom, $urandom} % (span + 64'h1_0000));
        if ($urandom_range(1) == 0) it.base[11:0] = '0;
        it.length = ($urandom_range(4) == 0) ? 64'($urandom_range(48 * 4096))
                                             : 64'($urandom_range(8 * 4096));
        it.rtype = TYPE_USABLE;
      end else if (s < 9) begin
        if (it.rtype == TYPE_USABLE) it.rtype = 32'd2;
      end else begin
        it.base = it.base | (64'd1 << (32 + $urandom_range(31)));
        it.rtype = TYPE_USABLE;
      end
    end else if (r >= add_pct + alloc_pct) begin
      it.kind = KIND_FREE;
      s = $urandom_range(9);
      if (s < 6 && handed_out.size() != 0) begin
        idx = $urandom_range(handed_out.size() - 1);
        it.freed = handed_out[idx];
        handed_out.delete(idx);
      end else if (s < 8) begin
        it.freed[11:0] = '0;
      end else begin
        it.freed = it.freed | (32'd1 << $urandom_range(11));
      end
    end
    return it;
  endfunction

  task automatic issue_request(page_req_t it);
    page_resp_t res;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    // Keep every pop on a written next pointer: push the head onto itself first.
    if (it.kind == KIND_ALLOC && board.pages_free != 0 &&
        !board.nxt_of.exists(board.head_frame)) begin
      it.kind = KIND_FREE;
      it.freed = 32'({board.head_frame, 12'b0});
    end
    kind_i          = it.kind;
    region_base_i   = it.base;
    region_length_i = it.length;
    region_type_i   = it.rtype;
    freed_address_i = it.freed;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    res = board.note_item(it);
    if (it.kind == KIND_ALLOC && res.status == ST_OK && handed_out.size() < 256) begin
      handed_out.push_back(res.page);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_window(reg_e r, logic [CFG_W-1:0] v);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 3'b000};
    pwdata  = {31'b0, v};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_window(r, v);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi, int n,
                           int add_pct, int alloc_pct, int calm_items);
    settle();
    write_window(REG_WINDOW_LOW, lo);
    write_window(REG_WINDOW_HIGH, hi);
    for (int i = 0; i < n; i++) begin
      calm = (i < calm_items);
      issue_request(pick_request(add_pct, alloc_pct));
    end
    calm = 1'b0;
  endtask

  task automatic drain_list();
    int n;
    n = 0;
    while (board.pages_free != 0 && n < 3000) begin
      issue_request(make_req(KIND_ALLOC, '0, '0, '0, '0));
      n++;
    end
  endtask

  initial begin
    board           = new();
    calm            = 1'b0;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    out_ready_i     = 1'b0;
    kind_i          = KIND_ADD;
    region_base_i   = '0;
    region_length_i = '0;
    region_type_i   = '0;
    freed_address_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    issue_request(make_req(KIND_ALLOC, '0, '0, '0, '0));
    issue_request(make_req(KIND_FREE, '0, '0, '0, 32'h0000_0001));
    issue_request(make_req(KIND_FREE, '0, '0, '0, 32'hFFFF_FFFF));
    issue_request(make_req(KIND_FREE, '1, '1, '1, 32'h0000_0000));
    issue_request(make_req(KIND_ALLOC, '0, '0, '0, '0));
    issue_request(make_req(KIND_ADD, 64'h80_0000, 64'h1_0000, 32'd0, '0));
    issue_request(make_req(KIND_ADD, 64'h80_0000, 64'h1_0000, 32'hFFFF_FFFF, '0));
    issue_request(make_req(KIND_ADD, 64'h80_0000, 64'h3000, TYPE_USABLE, '0));
    issue_request(make_req(KIND_ADD, 64'h7F_F001, 64'h3000, TYPE_USABLE, '0));
    issue_request(make_req(KIND_ADD, 64'h90_0001, 64'h1FFF, TYPE_USABLE, '0));
    issue_request(make_req(KIND_ADD, 64'h90_0000, 64'h0, TYPE_USABLE, '0));
    issue_request(make_req(KIND_ADD, 64'h90_0000, 64'hFFF, TYPE_USABLE, '0));
    issue_request(make_req(KIND_ADD, 64'hFFFF_F000, '1, TYPE_USABLE, '0));
    issue_request(make_req(KIND_ADD, 64'hFFFF_FFFF_FFFF_F001, 64'd5, TYPE_USABLE, '0));
    issue_request(make_req(KIND_ADD, '1, '1, TYPE_USABLE, '0));
    issue_request(make_req(KIND_ADD, 64'h1_0000_0000, 64'h1_0000, TYPE_USABLE, '0));
    issue_request(make_req(KIND_FREE, '0, '0, '0, 32'hFFFF_F000));
    issue_request(make_req(KIND_FREE, '0, '0, '0, 32'hABCD_E000));
    issue_request(make_req(KIND_FREE, '0, '0, '0, 32'h0010_0000));
    repeat (4) issue_request(make_req(KIND_ALLOC, '0, '0, '0, '0));

    run_phase(33'h0_0000_0000, 33'h1_0000_0000, 200, 20, 45, 0);
    run_phase(33'h0_1234_5678, 33'h0_1240_0800, 300, 30, 35, 0);
    drain_list();
    run_phase(33'h0_0000_0000, 33'h0_0000_0000, 120, 20, 60, 0);
    run_phase(33'h1_FFFF_FFFF, 33'h1_FFFF_FFFF, 120, 25, 45, 0);
    run_phase(33'h0_FFFF_0000, 33'h1_0000_0000, 300, 30, 40, 0);
    run_phase(33'h0_0040_0000, 33'h0_0040_0000, 100, 20, 55, 0);
    run_phase(WINDOW_LOW_RST, WINDOW_HIGH_RST, 360, 28, 40, 250);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pffl_pkg.sv
rtl/pffl_ram.sv
rtl/page_frame_free_list_top.sv
test/tb_page_frame_free_list_top.sv
